FILE: hw/rtl/md5_pkg.sv
`timescale 1ns / 1ps

package md5_pkg;

    // Working or chaining words of one MD5 compression
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] c;
        logic [31:0] b;
        logic [31:0] a;
    } md5_words_t;

    // Initial chaining vector
    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hEFCDAB89;
    localparam logic [31:0] MD5_IV_C = 32'h98BADCFE;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    localparam logic [7:0] MD5_PAD_BYTE = 8'h80;
    localparam logic [5:0] MD5_LAST_POS = 6'h3F;
    localparam logic [5:0] MD5_LAST_STEP = 6'd63;

    // Round constants, one per step
    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {round, step[1:0]}
    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a step (all products taken mod 16)
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] step);
        logic [3:0] lo;
        logic [3:0] g;
        lo = step[3:0];
        case (step[5:4])
            2'd0: g = lo;
            2'd1: g = lo + {lo[1:0], 2'b00} + 4'd1;
            2'd2: g = lo + {lo[2:0], 1'b0} + 4'd5;
            2'd3: g = {lo[0], 3'b000} - lo;
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

FILE: hw/rtl/md5_hash_stream.sv
`timescale 1ns / 1ps
// Byte-serial MD5 hasher. A byte that does not fill a block is only stored. A byte that
// fills a block is loaded, then runs 64 shared round steps and one add. On last the padding
// goes in a byte a cycle, except while a full block is compressed, and one or two blocks are
// compressed; the digest transaction is offered after the final add, later if the output
// register still holds a digest. That register lets the next message flow.
// aresetn (synchronous, active low) loads the initial vector and clears length and position.
module md5_hash_stream
    import md5_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_tuser,   // [0] byte_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [31:0] digest_word0 .. [127:96] digest_word3
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    md5_words_t  chain_reg, chain_next;
    md5_words_t  work_reg, work_next;
    logic [5:0]  step_reg, step_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic        fin_reg, fin_next;        // message ends: pad after current block
    logic        pad_first_reg, pad_first_next;
    logic        final_blk_reg, final_blk_next;
    logic        done_reg, done_next;      // block in work carries the length
    logic [127:0] out_reg, out_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] blk_reg [16];

    logic        wr_en;
    logic [7:0]  wr_byte;
    logic [31:0] msg_word;
    logic [31:0] b_new;
    logic [7:0]  len_byte;

    // Shared step unit
    assign msg_word = blk_reg[md5_msg_idx(step_reg)];

    md5_round u_round (
        .w        (work_reg),
        .step     (step_reg),
        .msg_word (msg_word),
        .b_new    (b_new)
    );

    assign len_byte = len_reg[{pos_reg[2:0], 3'b000} +: 8];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        fin_next       = fin_reg;
        pad_first_next = pad_first_reg;
        final_blk_next = final_blk_reg;
        done_next      = done_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg & ~m_tready;
        wr_en          = 1'b0;
        wr_byte        = 8'd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next       = s_tlast;
                    pad_first_next = 1'b1;
                    if (s_tuser[0]) begin
                        wr_en    = 1'b1;
                        wr_byte  = s_tdata;
                        len_next = len_reg + 64'd8;
                    end
                    if (s_tuser[0] && pos_reg == MD5_LAST_POS) begin
                        work_next  = chain_reg;
                        step_next  = 6'd0;
                        state_next = ST_ROUND;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (pad_first_reg) begin
                    wr_byte        = MD5_PAD_BYTE;
                    pad_first_next = 1'b0;
                    final_blk_next = (pos_reg[5:3] != 3'd7);
                end else if (final_blk_reg && pos_reg[5:3] == 3'd7) begin
                    wr_byte = len_byte;
                end else begin
                    wr_byte = 8'd0;
                end
                if (pos_reg == MD5_LAST_POS) begin
                    done_next      = final_blk_reg && !pad_first_reg;
                    final_blk_next = 1'b1;
                    work_next      = chain_reg;
                    step_next      = 6'd0;
                    state_next     = ST_ROUND;
                end
            end
            ST_ROUND: begin
                work_next.a = work_reg.d;
                work_next.b = b_new;
                work_next.c = work_reg.b;
                work_next.d = work_reg.c;
                step_next   = step_reg + 6'd1;
                if (step_reg == MD5_LAST_STEP) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                if (done_reg) begin
                    state_next = ST_EMIT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_next       = {chain_reg.d, chain_reg.c, chain_reg.b, chain_reg.a};
                    m_valid_next   = 1'b1;
                    chain_next.a   = MD5_IV_A;
                    chain_next.b   = MD5_IV_B;
                    chain_next.c   = MD5_IV_C;
                    chain_next.d   = MD5_IV_D;
                    len_next       = 64'd0;
                    fin_next       = 1'b0;
                    done_next      = 1'b0;
                    final_blk_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en) begin
            pos_next = pos_reg + 6'd1;
        end
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chain_reg.a   <= MD5_IV_A;
            chain_reg.b   <= MD5_IV_B;
            chain_reg.c   <= MD5_IV_C;
            chain_reg.d   <= MD5_IV_D;
            step_reg      <= 6'd0;
            pos_reg       <= 6'd0;
            len_reg       <= 64'd0;
            fin_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            final_blk_reg <= 1'b0;
            done_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            fin_reg       <= fin_next;
            pad_first_reg <= pad_first_next;
            final_blk_reg <= final_blk_next;
            done_reg      <= done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload: working words, block buffer, digest
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        out_reg  <= out_next;
        if (wr_en) begin
            blk_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= wr_byte;
        end
    end

endmodule

FILE: hw/rtl/md5_round.sv
`timescale 1ns / 1ps

// One MD5 step: round function, constant add, rotate, add to b
module md5_round
    import md5_pkg::*;
(
    input  md5_words_t  w,
    input  logic [5:0]  step,
    input  logic [31:0] msg_word,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] t;
    logic [63:0] rot;
    logic [4:0]  sh;

    // Round function by quarter
    always_comb begin
        case (step[5:4])
            2'd0: f = (w.b & w.c) | (~w.b & w.d);
            2'd1: f = (w.b & w.d) | (w.c & ~w.d);
            2'd2: f = w.b ^ w.c ^ w.d;
            2'd3: f = w.c ^ (w.b | ~w.d);
            default: f = w.b ^ w.c ^ w.d;
        endcase
    end

    assign sh    = MD5_S[{step[5:4], step[1:0]}];
    assign t     = w.a + f + MD5_K[step] + msg_word;
    // Rotate left: upper half of the doubled word shifted
    assign rot   = {t, t} << sh;
    assign b_new = w.b + rot[63:32];

endmodule
